// File: hw/rtl/dlea_pkg.sv
package dlea_pkg;

  // Field widths.
  localparam int unsigned PixW     = 8;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned DimW     = 13;
  localparam int unsigned AngW     = 8;
  localparam int unsigned DegW     = 7;
  localparam int unsigned SinW     = 31;
  localparam int unsigned ProdW    = CoordW + SinW;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [DimW-1:0]   dim_t;
  typedef logic [DegW-1:0]   deg_t;
  typedef logic [SinW-1:0]   sin_t;
  typedef logic [ProdW-1:0]  prod_t;

  // Largest frame size in pixels and rows.
  localparam dim_t MaxWidth  = 13'd4096;
  localparam dim_t MaxHeight = 13'd4096;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgThreshold = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth     = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgHeight    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgCenter    = 8'd3;

  // Configuration reset values.
  localparam logic [PixW-1:0] ThresholdRst = 8'd64;
  localparam dim_t            WidthRst     = 13'd640;
  localparam dim_t            HeightRst    = 13'd480;
  localparam coord_t          CenterRst    = 12'd320;

  // Angle search runs over whole degrees 1 to 89.
  localparam deg_t FirstDeg   = 7'd1;
  localparam deg_t LastDeg    = 7'd89;
  localparam deg_t QuarterDeg = 7'd90;

  localparam longint unsigned PiQ30       = 64'd3373259426;
  localparam int unsigned     SeriesTerms = 12;

  // Sine of whole degrees in unsigned Q1.30, Taylor series to the x^25 term.
  // Term n is divided by (2n)(2n+1).
  function automatic sin_t sin_deg_q30(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned prod;
    int unsigned     n;
    x    = (longint'(k) * PiQ30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= SeriesTerms; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        8:       term = prod / 64'd272;
        9:       term = prod / 64'd342;
        10:      term = prod / 64'd420;
        11:      term = prod / 64'd506;
        12:      term = prod / 64'd600;
        default: term = '0;
      endcase
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return sin_t'(sum);
  endfunction

  typedef sin_t sin_tab_t [0:127];

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    int unsigned i;
    for (i = 0; i < 128; i++) begin
      if (i <= 90) begin
        tab[i] = sin_deg_q30(i);
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pix_take;
    logic ang_start;
    logic ang_sel;
    logic cap_center;
    logic cap_relative;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic found;
    logic ang_busy;
    logic ang_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/dlea_if.sv
interface dlea_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface dlea_res_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic [11:0]       top_left_x;
  logic [11:0]       top_right_x;
  logic [11:0]       top_row;
  logic [11:0]       bottom_left_x;
  logic [11:0]       bottom_right_x;
  logic [11:0]       bottom_row;
  logic signed [7:0] center_deviation;
  logic signed [7:0] relative_deviation;

  modport source (
    output valid, output found, output top_left_x, output top_right_x, output top_row,
    output bottom_left_x, output bottom_right_x, output bottom_row,
    output center_deviation, output relative_deviation, input ready
  );
  modport sink (
    input valid, input found, input top_left_x, input top_right_x, input top_row,
    input bottom_left_x, input bottom_right_x, input bottom_row,
    input center_deviation, input relative_deviation, output ready
  );
endinterface

interface dlea_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dlea_angle.sv
module dlea_angle
  import dlea_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  coord_t                 ua_i,
  input  coord_t                 ub_i,
  input  logic                   neg_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [AngW-1:0] angle_o
);

  logic   issue_q, v1_q, last1_q, done_q;
  deg_t   k_q, cnt_q;
  coord_t ua_q, ub_q;
  logic   neg_q;
  prod_t  prod_a_q, prod_b_q;
  prod_t  prod_a_d, prod_b_d;

  // One degree per cycle: cos side times |a|, sin side times |b|.
  always_comb begin
    prod_a_d = prod_t'(ua_q) * prod_t'(SinTab[QuarterDeg - k_q]);
    prod_b_d = prod_t'(ub_q) * prod_t'(SinTab[k_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      done_q  <= 1'b0;
      k_q     <= FirstDeg;
      cnt_q   <= '0;
    end else begin
      v1_q    <= issue_q;
      last1_q <= issue_q && (k_q == LastDeg);
      done_q  <= last1_q;
      if (start_i) begin
        issue_q <= 1'b1;
        k_q     <= FirstDeg;
      end else if (issue_q) begin
        k_q <= k_q + deg_t'(1);
        if (k_q == LastDeg) begin
          issue_q <= 1'b0;
        end
      end
      if (start_i) begin
        cnt_q <= '0;
      end else if (v1_q && (prod_a_q >= prod_b_q)) begin
        cnt_q <= cnt_q + deg_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= ua_i;
      ub_q  <= ub_i;
      neg_q <= neg_i;
    end
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
  end

  assign busy_o  = issue_q | v1_q;
  assign done_o  = done_q;
  assign angle_o = neg_q ? AngW'(AngW'(0) - AngW'(cnt_q)) : AngW'(cnt_q);

endmodule

// File: hw/rtl/dlea_ctrl.sv
module dlea_ctrl
  import dlea_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pix_valid_i,
  output logic      pix_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_SCAN    = 6'b000001,
    ST_START_C = 6'b000010,
    ST_WAIT_C  = 6'b000100,
    ST_START_R = 6'b001000,
    ST_WAIT_R  = 6'b010000,
    ST_LOAD    = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        take;

  assign pix_ready_o = (state_q == ST_SCAN);
  assign take        = pix_valid_i && pix_ready_o;

  always_comb begin
    cmd_o              = '0;
    cmd_o.pix_take     = take;
    cmd_o.ang_start    = (state_q == ST_START_C) || (state_q == ST_START_R);
    cmd_o.ang_sel      = (state_q == ST_START_R);
    cmd_o.cap_center   = (state_q == ST_WAIT_C) && sts_i.ang_done;
    cmd_o.cap_relative = (state_q == ST_WAIT_R) && sts_i.ang_done;
    cmd_o.out_load     = (state_q == ST_LOAD) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SCAN: begin
        if (take && sts_i.frame_end) begin
          state_d = sts_i.found ? ST_START_C : ST_LOAD;
        end
      end
      ST_START_C: state_d = ST_WAIT_C;
      ST_WAIT_C: begin
        if (sts_i.ang_done) begin
          state_d = ST_START_R;
        end
      end
      ST_START_R: state_d = ST_WAIT_R;
      ST_WAIT_R: begin
        if (sts_i.ang_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_SCAN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCAN;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register still full");

  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.ang_done |-> (state_q == ST_WAIT_C || state_q == ST_WAIT_R))
    else $error("angle unit finished outside a wait state");

  a_scan_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_ready_o |-> !sts_i.ang_busy)
    else $error("pixels accepted while the angle unit is running");

  a_start_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ang_start |=> sts_i.ang_busy)
    else $error("angle unit did not start");
`endif

endmodule

// File: hw/rtl/dlea_dp.sv
module dlea_dp
  import dlea_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [PixW-1:0] pixel_i,
  input  logic            sof_i,
  input  ctrl_cmd_t       cmd_i,
  output dp_sts_t         sts_o,
  dlea_cfg_if.sink        cfg_i,
  dlea_res_if.source      res_o
);

  // Configuration registers.
  logic [PixW-1:0] thr_q;
  dim_t            width_q, height_q;
  coord_t          center_q;

  // Scan state.
  coord_t col_q, row_q, rfd_q, rld_q;
  logic   rhd_q, any_q;
  coord_t tl_q, tr_q, trow_q, bl_q, br_q, brow_q;
  coord_t col_d, row_d, rfd_d, rld_d;
  logic   rhd_d, any_d;
  coord_t tl_d, tr_d, trow_d, bl_d, br_d, brow_d;

  // Frame snapshot, angles and output register.
  logic   snap_found_q;
  coord_t snap_tl_q, snap_tr_q, snap_trow_q, snap_bl_q, snap_br_q, snap_brow_q;
  logic signed [AngW-1:0] cdev_q, rdev_q;
  logic   out_valid_q;

  dim_t   w_eff, h_eff;
  coord_t eff_col, eff_row;
  logic   eff_rhd, eff_any;
  logic   dark, rhd1, row_end, row_last, frame_end;
  coord_t rfd1, rld1;
  logic   fin_any;
  coord_t fin_tl, fin_tr, fin_trow, fin_bl, fin_br, fin_brow;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThresholdRst;
      width_q  <= WidthRst;
      height_q <= HeightRst;
      center_q <= CenterRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgThreshold: thr_q    <= cfg_i.data[PixW-1:0];
        CfgWidth:     width_q  <= cfg_i.data[DimW-1:0];
        CfgHeight:    height_q <= cfg_i.data[DimW-1:0];
        CfgCenter:    center_q <= cfg_i.data[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_q == '0) ? dim_t'(1) : ((width_q > MaxWidth) ? MaxWidth : width_q);
    h_eff = (height_q == '0) ? dim_t'(1) : ((height_q > MaxHeight) ? MaxHeight : height_q);

    // A start mark drops the frame in progress.
    eff_col = sof_i ? '0 : col_q;
    eff_row = sof_i ? '0 : row_q;
    eff_rhd = sof_i ? 1'b0 : rhd_q;
    eff_any = sof_i ? 1'b0 : any_q;
    tl_d    = sof_i ? '0 : tl_q;
    tr_d    = sof_i ? '0 : tr_q;
    trow_d  = sof_i ? '0 : trow_q;
    bl_d    = sof_i ? '0 : bl_q;
    br_d    = sof_i ? '0 : br_q;
    brow_d  = sof_i ? '0 : brow_q;

    dark = (pixel_i <= thr_q);
    rhd1 = eff_rhd | dark;
    rfd1 = (dark && !eff_rhd) ? eff_col : rfd_q;
    rld1 = dark ? eff_col : rld_q;

    row_end   = (dim_t'(eff_col) + dim_t'(1)) >= w_eff;
    row_last  = (dim_t'(eff_row) + dim_t'(1)) >= h_eff;
    frame_end = row_end && row_last;

    col_d = eff_col + coord_t'(1);
    row_d = eff_row;
    rfd_d = rfd1;
    rld_d = rld1;
    rhd_d = rhd1;
    any_d = eff_any;

    if (row_end) begin
      col_d = '0;
      rhd_d = 1'b0;
      if (rhd1) begin
        if (!eff_any) begin
          tl_d   = rfd1;
          tr_d   = rld1;
          trow_d = eff_row;
        end
        bl_d   = rfd1;
        br_d   = rld1;
        brow_d = eff_row;
        any_d  = 1'b1;
      end
      if (!row_last) begin
        row_d = eff_row + coord_t'(1);
      end
    end

    fin_any  = any_d;
    fin_tl   = tl_d;
    fin_tr   = tr_d;
    fin_trow = trow_d;
    fin_bl   = bl_d;
    fin_br   = br_d;
    fin_brow = brow_d;

    if (frame_end) begin
      row_d  = '0;
      any_d  = 1'b0;
      tl_d   = '0;
      tr_d   = '0;
      trow_d = '0;
      bl_d   = '0;
      br_d   = '0;
      brow_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rfd_q  <= '0;
      rld_q  <= '0;
      rhd_q  <= 1'b0;
      any_q  <= 1'b0;
      tl_q   <= '0;
      tr_q   <= '0;
      trow_q <= '0;
      bl_q   <= '0;
      br_q   <= '0;
      brow_q <= '0;
    end else if (cmd_i.pix_take) begin
      col_q  <= col_d;
      row_q  <= row_d;
      rfd_q  <= rfd_d;
      rld_q  <= rld_d;
      rhd_q  <= rhd_d;
      any_q  <= any_d;
      tl_q   <= tl_d;
      tr_q   <= tr_d;
      trow_q <= trow_d;
      bl_q   <= bl_d;
      br_q   <= br_d;
      brow_q <= brow_d;
    end
  end

  // Angle operands from the snapshot.
  coord_t tmid, bmid;
  logic signed [DimW-1:0] a1, a2;
  coord_t ua1, ua2, ub1, ub2, ua_sel, ub_sel;
  logic   neg1, neg2, neg_sel;
  logic   ang_busy, ang_done;
  logic signed [AngW-1:0] angle;

  always_comb begin
    tmid = coord_t'((dim_t'(snap_tl_q) + dim_t'(snap_tr_q)) >> 1);
    bmid = coord_t'((dim_t'(snap_bl_q) + dim_t'(snap_br_q)) >> 1);
    a1   = $signed({1'b0, tmid}) - $signed({1'b0, center_q});
    a2   = $signed({1'b0, bmid}) - $signed({1'b0, tmid});
    ua1  = a1[DimW-1] ? coord_t'(-a1) : coord_t'(a1);
    ua2  = a2[DimW-1] ? coord_t'(-a2) : coord_t'(a2);
    ub1  = (snap_brow_q == '0) ? coord_t'(1) : snap_brow_q;
    // The top row never lies below the bottom row, so the row difference is positive or zero.
    ub2  = (snap_brow_q == snap_trow_q) ? coord_t'(1) : (snap_brow_q - snap_trow_q);
    neg1 = a1[DimW-1];
    neg2 = a2[DimW-1] != (snap_brow_q != snap_trow_q);
    ua_sel  = cmd_i.ang_sel ? ua2 : ua1;
    ub_sel  = cmd_i.ang_sel ? ub2 : ub1;
    neg_sel = cmd_i.ang_sel ? neg2 : neg1;
  end

  dlea_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ang_start),
    .ua_i    (ua_sel),
    .ub_i    (ub_sel),
    .neg_i   (neg_sel),
    .busy_o  (ang_busy),
    .done_o  (ang_done),
    .angle_o (angle)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take && frame_end) begin
      snap_found_q <= fin_any;
      snap_tl_q    <= fin_tl;
      snap_tr_q    <= fin_tr;
      snap_trow_q  <= fin_trow;
      snap_bl_q    <= fin_bl;
      snap_br_q    <= fin_br;
      snap_brow_q  <= fin_brow;
      cdev_q       <= '0;
      rdev_q       <= '0;
    end else begin
      if (cmd_i.cap_center) begin
        cdev_q <= angle;
      end
      if (cmd_i.cap_relative) begin
        rdev_q <= angle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_o.found              <= snap_found_q;
      res_o.top_left_x         <= snap_tl_q;
      res_o.top_right_x        <= snap_tr_q;
      res_o.top_row            <= snap_trow_q;
      res_o.bottom_left_x      <= snap_bl_q;
      res_o.bottom_right_x     <= snap_br_q;
      res_o.bottom_row         <= snap_brow_q;
      res_o.center_deviation   <= cdev_q;
      res_o.relative_deviation <= rdev_q;
    end
  end

  assign res_o.valid = out_valid_q;

  always_comb begin
    sts_o           = '0;
    sts_o.frame_end = frame_end;
    sts_o.found     = fin_any;
    sts_o.ang_busy  = ang_busy;
    sts_o.ang_done  = ang_done;
    sts_o.out_free  = !out_valid_q || res_o.ready;
  end

endmodule

// File: hw/rtl/dark_line_extent_angle_core.sv
// Dark line extent and angle finder.
//
// Gray pixels arrive in raster order on pix_i; start_of_frame marks the
// first pixel of a frame and restarts the row and column counters. Within
// a frame one pixel is taken every cycle. After the last pixel of a frame
// one result leaves on res_o: whether any pixel was dark, the leftmost and
// rightmost dark column of the first and last dark rows, and two angles in
// whole degrees.
// A frame without dark pixels goes straight to the result load. Otherwise
// the shared angle unit first searches degrees 1 to 89 once per angle, one
// degree per cycle on a pair of 12 x 31 bit multipliers; no pixel is taken
// during the searches. The result sits in an output register, so the next
// frame streams in while it waits; a stalled receiver holds pixel input
// only at the next frame end. Configuration writes on cfg_i complete every
// cycle; the user must make them only while the block is idle, which the
// block does not enforce. Reset restores the register defaults and clears
// the counters and any pending result.
module dark_line_extent_angle_core
  import dlea_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dlea_pix_if.sink    pix_i,
  dlea_res_if.source  res_o,
  dlea_cfg_if.sink    cfg_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      pix_ready;

  // The controller sequences scan, the two angle searches and the result load.
  dlea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign pix_i.ready = pix_ready;

  // The datapath holds counters, extents, the angle unit and the output register.
  dlea_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pix_i.pixel),
    .sof_i   (pix_i.start_of_frame),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .cfg_i   (cfg_i),
    .res_o   (res_o)
  );

endmodule
